// ===== src/assert_macros.svh =====
// Assertion macros for the port-level checker of the timer queue.
// Depends on nothing; a file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define TQE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("timer queue check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define TQE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("timer queue check failed");

`endif

// ===== src/tqe_pkg.sv =====
// Types and constants of the sorted timer queue.
// Used by the slot cell, the top level and the checker; depends on nothing.
package tqe_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned MAX_OUT  = 16;
  localparam int unsigned CNT_W    = $clog2(MAX_OUT);

  localparam int unsigned TIME_W = 64;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned DLY_W  = 32;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_CREATED   = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_CANCELLED = 2'd2,
    KIND_FIRED     = 2'd3
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } slot_t;

  // Update commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic remove;
    logic pop;
  } cmd_t;

endpackage

// ===== src/timer_event_queue.sv =====
// Sorted timer queue: top level with the sequencer, time and id counters.
// Depends on tqe_pkg and instantiates a chain of CAPACITY tqe_cell slots.
//
// Up to 16 pending timers are kept sorted by deadline in a chain of slot cells,
// earlier creation first among equal deadlines; the whole chain moves by one
// place in one update on insert, cancel or expiry. A request is taken only
// while the block is idle. A create or cancel passes through capture, deadline
// sum and chain update, and its result sits in the output register from then
// on. A tick passes through capture and time increment, then pops expired
// timers, if any, one head pop per cycle while the result side does not stall,
// at most 16 per tick. No clearing pass follows reset: the queue is empty at once.
module timer_event_queue import tqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [DLY_W-1:0] delay_i,
  input  logic [ID_W-1:0]  cancel_id_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [ID_W-1:0]  timer_id_o,
  output logic             found_o,
  output logic             last_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_APPLY = 4'b0100,
    S_POP   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        op_q;
  logic [DLY_W-1:0]  delay_q;
  logic [ID_W-1:0]   cid_q;
  logic [TIME_W-1:0] dl_q, dl_d;
  logic              issued_q, issued_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [ID_W-1:0]   tid_q, tid_d;
  logic              found_q, found_d;
  logic              last_q, last_d;
  logic              load_out;

  cmd_t              cmd;
  slot_t             new_slot;
  slot_t             slots  [CAPACITY];
  slot_t             nbr    [CAPACITY+1];
  logic              after  [CAPACITY+1];
  logic              match  [CAPACITY+1];
  logic [TIME_W:0]   dl_sum;
  logic              accept_in;
  logic              out_free;
  logic              head_exp;
  logic              next_exp;
  logic              full;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept_in  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign new_slot.valid    = 1'b1;
  assign new_slot.deadline = dl_q;
  assign new_slot.id       = next_id_q;

  assign after[0] = 1'b1;
  assign match[0] = 1'b0;
  assign nbr[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slot_t left_s;
    assign nbr[g]  = slots[g];
    assign left_s  = (g == 0) ? new_slot : slots[(g == 0) ? 0 : g-1];

    tqe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .new_i       (new_slot),
      .cancel_id_i (cid_q),
      .left_i      (left_s),
      .right_i     (nbr[g+1]),
      .after_i     (after[g]),
      .match_i     (match[g]),
      .after_o     (after[g+1]),
      .match_o     (match[g+1]),
      .slot_o      (slots[g])
    );
  end

  assign full     = slots[CAPACITY-1].valid;
  assign head_exp = nbr[0].valid && (nbr[0].deadline <= time_q);
  assign next_exp = nbr[1].valid && (nbr[1].deadline <= time_q);
  assign dl_sum   = {1'b0, time_q} + {{(TIME_W+1-DLY_W){1'b0}}, delay_q};

  always_comb begin
    state_d   = state_q;
    dl_d      = dl_q;
    issued_d  = issued_q;
    time_d    = time_q;
    next_id_d = next_id_q;
    cnt_d     = cnt_q;
    cmd       = '0;
    load_out  = 1'b0;
    kind_d    = kind_q;
    tid_d     = tid_q;
    found_d   = 1'b0;
    last_d    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        // A deadline beyond the time range saturates.
        dl_d     = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
        issued_d = (cid_q != '0) && ((next_id_q == '0) || (cid_q < next_id_q));
        cnt_d    = '0;
        case (op_q)
          OP_CREATE, OP_CANCEL: state_d = S_APPLY;
          OP_TICK: begin
            time_d  = time_q + TIME_W'(1);
            state_d = S_POP;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_APPLY: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          if (op_q == OP_CANCEL) begin
            cmd.remove = issued_q;
            kind_d     = KIND_CANCELLED;
            tid_d      = cid_q;
            found_d    = issued_q && match[CAPACITY];
          end else if (full || (next_id_q == '0)) begin
            kind_d = KIND_REJECTED;
            tid_d  = '0;
          end else begin
            cmd.insert = 1'b1;
            kind_d     = KIND_CREATED;
            tid_d      = next_id_q;
            next_id_d  = next_id_q + ID_W'(1);
          end
        end
      end
      S_POP: begin
        if (!head_exp) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          cmd.pop  = 1'b1;
          kind_d   = KIND_FIRED;
          tid_d    = nbr[0].id;
          last_d   = !next_exp || (cnt_q == CNT_W'(MAX_OUT-1));
          cnt_d    = cnt_q + CNT_W'(1);
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      next_id_q   <= ID_W'(1);
      cnt_q       <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      next_id_q   <= next_id_d;
      cnt_q       <= cnt_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q    <= operation_i;
      delay_q <= delay_i;
      cid_q   <= cancel_id_i;
    end
    dl_q <= dl_d;
    if (load_out) begin
      kind_q  <= kind_d;
      tid_q   <= tid_d;
      found_q <= found_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign timer_id_o  = tid_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

endmodule

// ===== src/tqe_cell.sv =====
// One slot of the sorted timer chain: holds a deadline and an id.
// Depends on tqe_pkg; neighbours are wired by timer_event_queue.
module tqe_cell import tqe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  slot_t           new_i,
  input  logic [ID_W-1:0] cancel_id_i,
  input  slot_t           left_i,
  input  slot_t           right_i,
  input  logic            after_i,
  input  logic            match_i,
  output logic            after_o,
  output logic            match_o,
  output slot_t           slot_o
);

  slot_t slot_q, slot_d;

  // A new timer goes behind every pending one with an equal or earlier deadline.
  assign after_o = slot_q.valid && (slot_q.deadline <= new_i.deadline);
  // Once the cancelled id is seen, this cell and all to its right close the gap.
  assign match_o = match_i || (slot_q.valid && (slot_q.id == cancel_id_i));
  assign slot_o  = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.insert) begin
      if (!after_o) begin
        slot_d = after_i ? new_i : left_i;
      end
    end else if (cmd_i.remove) begin
      if (match_o) begin
        slot_d = right_i;
      end
    end else if (cmd_i.pop) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== src/tqe_checker.sv =====
// Port-level checks of the timer queue, bound to timer_event_queue.
// Depends on tqe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tqe_checker import tqe_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [1:0]       operation_i,
  input logic [DLY_W-1:0] delay_i,
  input logic [ID_W-1:0]  cancel_id_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       kind_o,
  input logic [ID_W-1:0]  timer_id_o,
  input logic             found_o,
  input logic             last_o
);

  // A stalled result stays offered.
  `TQE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // The block works on one request at a time: it is busy right after taking one.
  `TQE_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // A rejected create carries no id and no found flag.
  `TQE_ASSERT_NOW(a_reject_clean, out_valid_o && (kind_o == KIND_REJECTED),
                  (timer_id_o == '0) && !found_o)

  // Create and cancel give a single result, so it is always the last one.
  `TQE_ASSERT_NOW(a_single_last, out_valid_o && (kind_o != KIND_FIRED), last_o)

  // Only a cancel can report a found timer.
  `TQE_ASSERT_NOW(a_found_cancel, out_valid_o && found_o, kind_o == KIND_CANCELLED)

endmodule

bind timer_event_queue tqe_checker u_tqe_checker (.*);

// ===== test/timer_queue_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sorted timer queue: watches the request and result channels, keeps
// its own copy of the pending timers and compares every result with its prediction.
// Depends on tqe_pkg for the operation and result codes and the queue sizes.
module timer_queue_checker import tqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       operation_i,
  input  logic [DLY_W-1:0] delay_i,
  input  logic [ID_W-1:0]  cancel_id_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       kind_i,
  input  logic [ID_W-1:0]  timer_id_i,
  input  logic             found_i,
  input  logic             last_i,
  input  logic             wrap_up_i,
  output int               pending_o,
  output int               fail_count_o
);

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] id;
    logic            found;
    logic            last;
  } timer_result_t;

  // Far more than the results of one request plus the one still held at the output.
  localparam int EXP_DEPTH = 64;

  logic [TIME_W-1:0] now_time;
  logic [ID_W-1:0]   next_id;
  logic [TIME_W-1:0] armed_deadline [CAPACITY];
  logic [ID_W-1:0]   armed_id [CAPACITY];
  int                armed_count;
  timer_result_t     expected_results [EXP_DEPTH];
  int                exp_head;
  int                exp_count;

  int   errors = 0;
  int   n_created, n_rejected, n_cancel_hit, n_cancel_miss, n_fired, widest_tick;
  logic wrapped_up;

  task automatic report(input string what, input logic [ID_W-1:0] got,
                        input logic [ID_W-1:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void push_result(input kind_e kind, input logic [ID_W-1:0] id,
                                      input logic found, input logic last);
    timer_result_t r;
    r.kind  = kind;
    r.id    = id;
    r.found = found;
    r.last  = last;
    expected_results[(exp_head + exp_count) % EXP_DEPTH] = r;
    exp_count++;
  endfunction

  // Closes the gap left by a removed timer so that the pending ones stay a prefix.
  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < armed_count; i++) begin
      armed_deadline[i] = armed_deadline[i + 1];
      armed_id[i]       = armed_id[i + 1];
    end
    armed_count--;
  endfunction

  task automatic apply_request(input logic [1:0] op, input logic [DLY_W-1:0] dly,
                               input logic [ID_W-1:0] cid);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] due;
    logic              hit;
    int                pos;
    int                i;
    int                fired;
    case (op)
      OP_CREATE: begin
        if (armed_count >= int'(CAPACITY) || next_id == '0) begin
          push_result(KIND_REJECTED, '0, 1'b0, 1'b1);
          n_rejected++;
        end else begin
          sum = {1'b0, now_time} + {{(TIME_W + 1 - DLY_W){1'b0}}, dly};
          due = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          // Equal deadlines go behind the older timers.
          pos = 0;
          while (pos < armed_count && armed_deadline[pos] <= due) pos++;
          for (i = armed_count; i > pos; i--) begin
            armed_deadline[i] = armed_deadline[i - 1];
            armed_id[i]       = armed_id[i - 1];
          end
          armed_deadline[pos] = due;
          armed_id[pos]       = next_id;
          armed_count++;
          push_result(KIND_CREATED, next_id, 1'b0, 1'b1);
          next_id = next_id + 1'b1;
          n_created++;
        end
      end
      OP_CANCEL: begin
        hit = 1'b0;
        if (cid != '0 && (next_id == '0 || cid < next_id)) begin
          for (i = 0; i < armed_count && !hit; i++) begin
            if (armed_id[i] == cid) begin
              drop_slot(i);
              hit = 1'b1;
            end
          end
        end
        push_result(KIND_CANCELLED, cid, hit, 1'b1);
        if (hit) n_cancel_hit++;
        else n_cancel_miss++;
      end
      OP_TICK: begin
        now_time = now_time + 1'b1;
        fired = 0;
        while (fired < int'(MAX_OUT) && armed_count > 0 && armed_deadline[0] <= now_time) begin
          push_result(KIND_FIRED, armed_id[0], 1'b0, 1'b0);
          drop_slot(0);
          fired++;
        end
        if (fired > 0) begin
          expected_results[(exp_head + exp_count - 1) % EXP_DEPTH].last = 1'b1;
        end
        n_fired += fired;
        if (fired > widest_tick) widest_tick = fired;
      end
      default: ;  // the spare operation code leaves the queue untouched
    endcase
  endtask

  task automatic check_result();
    timer_result_t want;
    if (exp_count == 0) begin
      report("result with none expected, timer_id", timer_id_i, '0);
    end else begin
      want = expected_results[exp_head];
      exp_head = (exp_head + 1) % EXP_DEPTH;
      exp_count--;
      if (kind_i !== want.kind) report("kind", ID_W'(kind_i), ID_W'(want.kind));
      if (timer_id_i !== want.id) report("timer_id", timer_id_i, want.id);
      if (found_i !== want.found) report("found", ID_W'(found_i), ID_W'(want.found));
      if (last_i !== want.last) report("last", ID_W'(last_i), ID_W'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_time      = '0;
      next_id       = 1;
      armed_count   = 0;
      n_created     = 0;
      n_rejected    = 0;
      n_cancel_hit  = 0;
      n_cancel_miss = 0;
      n_fired       = 0;
      widest_tick   = 0;
      wrapped_up    = 1'b0;
      exp_head      = 0;
      exp_count     = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Results are compared before the request of this edge is predicted.
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) apply_request(operation_i, delay_i, cancel_id_i);
      if (wrap_up_i && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (exp_count != 0)
          report("results still outstanding at the end", ID_W'(exp_count), '0);
        $display("Run covered %0d timers created, %0d creates refused, %0d cancels removing",
                 n_created, n_rejected, n_cancel_hit);
        $display("a timer and %0d missing; %0d timers fired, at most %0d on one tick.",
                 n_cancel_miss, n_fired, widest_tick);
      end
      pending_o    <= exp_count;
      fail_count_o <= errors;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the sorted timer queue: clock, reset, request and result drivers.
// Depends on tqe_pkg, timer_event_queue and timer_queue_checker.
module tb;
  import tqe_pkg::*;

  localparam int ITEMS          = 410;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       operation = OP_TICK;
  logic [DLY_W-1:0] delay = '0;
  logic [ID_W-1:0]  cancel_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       kind;
  logic [ID_W-1:0]  timer_id;
  logic             found;
  logic             last;
  logic             wrap_up = 1'b0;
  int               pending_count;
  int               fail_count;

  int requests_sent = 0;
  int ids_issued = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  timer_event_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .delay_i     (delay),
    .cancel_id_i (cancel_id),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .timer_id_o  (timer_id),
    .found_o     (found),
    .last_o      (last)
  );

  timer_queue_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .delay_i      (delay),
    .cancel_id_i  (cancel_id),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .timer_id_i   (timer_id),
    .found_i      (found),
    .last_i       (last),
    .wrap_up_i    (wrap_up),
    .pending_o    (pending_count),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random hold-off before each result, or one long hold on request.
  initial begin
    int wait_cycles;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        wait_cycles = steady ? 0 : $urandom_range(0, 4);
        if (wait_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [DLY_W-1:0] dly,
                              input logic [ID_W-1:0] cid);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    delay     <= dly;
    cancel_id <= cid;
    do @(posedge clk); while (in_stall);
    if (op != OP_SPARE) requests_sent++;
    if (op == OP_CREATE) ids_issued++;
  endtask

  // Holds the request side back until every expected result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int choice;
    int count;
    int lo;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Equal deadlines, zero delay and a quiet tick.
    send_request(OP_CREATE, 0, 0);
    send_request(OP_CREATE, 0, 0);
    send_request(OP_CREATE, 1, 0);
    send_request(OP_TICK, 0, 0);
    send_request(OP_TICK, '1, '1);
    // Longest delay, then cancels that hit, miss, use id zero and unissued ids.
    send_request(OP_CREATE, 32'hFFFF_FFFF, 0);
    send_request(OP_CREATE, 3, 0);
    send_request(OP_CANCEL, 0, 4);
    send_request(OP_CANCEL, 0, 4);
    send_request(OP_CANCEL, 0, 0);
    send_request(OP_CANCEL, 0, 32'hFFFF_FFFF);
    send_request(OP_SPARE, '1, '1);
    send_request(OP_SPARE, 0, 0);
    send_request(OP_CREATE, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_CREATE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OP_CANCEL, 0, 6);
    send_request(OP_CANCEL, 0, 7);
    send_request(OP_CANCEL, 0, 32'h5555_5555);
    send_request(OP_CANCEL, 0, 32'hAAAA_AAAA);
    repeat (4) send_request(OP_TICK, 0, 0);
    wait_for_drain();

    // Fill the queue to refusal, then let every timer expire on a single tick.
    repeat (CAPACITY + 1) send_request(OP_CREATE, 0, 0);
    send_request(OP_TICK, 0, 0);

    while (requests_sent < ITEMS) begin
      steady = ((requests_sent / 40) % 5) == 4;
      if (!hold_done && requests_sent >= 120) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && requests_sent >= 250) begin
        wait_for_drain();
        pause_done = 1'b1;
      end
      choice = $urandom_range(0, 19);
      if (choice < 2) begin
        // A burst of near deadlines followed by a few ticks.
        count = $urandom_range(3, 18);
        repeat (count) send_request(OP_CREATE, $urandom_range(0, 3), $urandom());
        count = $urandom_range(1, 5);
        repeat (count) send_request(OP_TICK, $urandom(), $urandom());
      end else if (choice == 2) begin
        case ($urandom_range(0, 2))
          0:       send_request(OP_SPARE, $urandom(), $urandom());
          1:       send_request(OP_CREATE, $urandom(), $urandom());
          default: send_request(OP_CANCEL, $urandom(), $urandom());
        endcase
      end else begin
        choice = $urandom_range(0, 99);
        lo = (ids_issued > 24) ? ids_issued - 24 : 0;
        if (choice < 40) begin
          if ($urandom_range(0, 49) == 0) send_request(OP_CREATE, $urandom(), $urandom());
          else send_request(OP_CREATE, $urandom_range(0, 10), $urandom());
        end else if (choice < 65) begin
          if ($urandom_range(0, 9) == 0)
            send_request(OP_CANCEL, $urandom(), $urandom());
          else if ($urandom_range(0, 3) == 0)
            send_request(OP_CANCEL, $urandom(), $urandom_range(0, ids_issued + 2));
          else
            send_request(OP_CANCEL, $urandom(), $urandom_range(lo, ids_issued + 2));
        end else begin
          send_request(OP_TICK, $urandom(), $urandom());
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tqe_pkg.sv
src/tqe_cell.sv
src/timer_event_queue.sv
src/tqe_checker.sv
test/timer_queue_checker.sv
test/tb.sv
